### hdl/tfs_pkg.sv
// shared types and constants for the transmit frame slot scheduler
`timescale 1ns / 1ps

package tfs_pkg;

    // field widths
    localparam int TIME_W     = 48;
    localparam int PERIOD_W   = 20;
    localparam int HANG_W     = 8;
    localparam int READY_W    = 8;
    localparam int TOTAL_W    = 32;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // register reset values
    localparam logic [HANG_W-1:0]   HANG_FRAMES_RESET  = '0;
    localparam logic [PERIOD_W-1:0] FRAME_PERIOD_RESET = PERIOD_W'(40000);

    // register indexes (byte address bit 2)
    localparam logic REG_HANG_FRAMES  = 1'b0;
    localparam logic REG_FRAME_PERIOD = 1'b1;

    typedef enum logic [1:0] {
        ACT_SET_TIME = 2'd0,
        ACT_READY    = 2'd1,
        ACT_TICK     = 2'd2,
        ACT_START    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_REAL  = 2'd1,
        KIND_DUMMY = 2'd2,
        KIND_POST  = 2'd3
    } frame_kind_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [TIME_W-1:0] time_us;
    } sched_in_t;

    typedef struct packed {
        logic [1:0]         frame_kind;
        logic               hang_active;
        logic               session_active;
        logic               session_ended;
        logic [TOTAL_W-1:0] untimely_count;
        logic [TOTAL_W-1:0] dummy_count;
        logic [TIME_W-1:0]  next_decision_us;
    } sched_out_t;

    typedef struct packed {
        logic [HANG_W-1:0]   hang_frames;
        logic [PERIOD_W-1:0] frame_period_us;
    } tfs_cfg_t;

endpackage

### hdl/tfs_cfg_regs.sv
// apb register file holding hang length and frame period
`timescale 1ns / 1ps

module tfs_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tfs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tfs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tfs_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output tfs_pkg::tfs_cfg_t              cfg
);
    import tfs_pkg::*;

    logic [HANG_W-1:0]   hang_frames_reg;
    logic [PERIOD_W-1:0] frame_period_reg;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hang_frames_reg  <= HANG_FRAMES_RESET;
            frame_period_reg <= FRAME_PERIOD_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_HANG_FRAMES)
                hang_frames_reg <= pwdata[HANG_W-1:0];
            else
                frame_period_reg <= pwdata[PERIOD_W-1:0];
        end
    end

    // read mux
    always_comb
    begin
        if (paddr[2] == REG_FRAME_PERIOD)
            prdata = {{(APB_DATA_W-PERIOD_W){1'b0}}, frame_period_reg};
        else
            prdata = {{(APB_DATA_W-HANG_W){1'b0}}, hang_frames_reg};
    end

    assign cfg.hang_frames     = hang_frames_reg;
    assign cfg.frame_period_us = frame_period_reg;

endmodule

### hdl/tfs_slot_core.sv
// scheduler state and per-beat slot decision logic
`timescale 1ns / 1ps

module tfs_slot_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                exec,
    input  tfs_pkg::sched_in_t  beat,
    input  tfs_pkg::tfs_cfg_t   cfg,
    output tfs_pkg::sched_out_t result
);
    import tfs_pkg::*;

    logic [TIME_W-1:0]  decision_reg, decision_next;
    logic [READY_W-1:0] ready_reg, ready_next;
    logic [HANG_W-1:0]  hang_cnt_reg, hang_cnt_next;
    logic               active_reg, active_next;
    logic               hang_flag_reg, hang_flag_next;
    logic [TOTAL_W-1:0] untimely_reg, untimely_next;
    logic [TOTAL_W-1:0] dummy_reg, dummy_next;
    frame_kind_t        kind;
    logic               ended;
    logic               slot_due;

    assign slot_due = active_reg && (decision_reg != '0) && (beat.time_us >= decision_reg);

    // next state for the current beat
    always_comb
    begin
        decision_next  = decision_reg;
        ready_next     = ready_reg;
        hang_cnt_next  = hang_cnt_reg;
        active_next    = active_reg;
        hang_flag_next = hang_flag_reg;
        untimely_next  = untimely_reg;
        dummy_next     = dummy_reg;
        kind           = KIND_NONE;
        ended          = 1'b0;
        case (action_t'(beat.action))
            ACT_SET_TIME:
            begin
                decision_next = beat.time_us;
            end
            ACT_READY:
            begin
                if (ready_reg != {READY_W{1'b1}})
                    ready_next = ready_reg + READY_W'(1);
            end
            ACT_TICK:
            begin
                if (slot_due)
                begin
                    if (ready_reg != '0)
                    begin
                        // extra ready frames were overwritten
                        untimely_next  = untimely_reg + {{(TOTAL_W-READY_W){1'b0}}, ready_reg}
                                         - TOTAL_W'(1);
                        hang_cnt_next  = '0;
                        hang_flag_next = 1'b0;
                        kind           = KIND_REAL;
                    end
                    else if (hang_cnt_reg >= cfg.hang_frames)
                    begin
                        // hang period over, postamble ends the session
                        hang_cnt_next  = '0;
                        hang_flag_next = 1'b0;
                        active_next    = 1'b0;
                        ended          = 1'b1;
                        kind           = KIND_POST;
                    end
                    else
                    begin
                        dummy_next     = dummy_reg + TOTAL_W'(1);
                        hang_cnt_next  = hang_cnt_reg + HANG_W'(1);
                        hang_flag_next = 1'b1;
                        kind           = KIND_DUMMY;
                    end
                    decision_next = decision_reg
                                    + {{(TIME_W-PERIOD_W){1'b0}}, cfg.frame_period_us};
                    ready_next    = '0;
                end
            end
            ACT_START:
            begin
                active_next = 1'b1;
            end
            default:
            begin
                active_next = active_reg;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decision_reg  <= '0;
            ready_reg     <= '0;
            hang_cnt_reg  <= '0;
            active_reg    <= 1'b0;
            hang_flag_reg <= 1'b0;
            untimely_reg  <= '0;
            dummy_reg     <= '0;
        end
        else if (exec)
        begin
            decision_reg  <= decision_next;
            ready_reg     <= ready_next;
            hang_cnt_reg  <= hang_cnt_next;
            active_reg    <= active_next;
            hang_flag_reg <= hang_flag_next;
            untimely_reg  <= untimely_next;
            dummy_reg     <= dummy_next;
        end
    end

    // result for this beat
    assign result.frame_kind       = kind;
    assign result.hang_active      = hang_flag_next;
    assign result.session_active   = active_next;
    assign result.session_ended    = ended;
    assign result.untimely_count   = untimely_next;
    assign result.dummy_count      = dummy_next;
    assign result.next_decision_us = decision_next;

endmodule

### hdl/tx_frame_slot_scheduler.sv
// Transmit frame slot scheduler top level: input register, slot logic, result register.
// An accepted beat passes through the input register and then the result register to out_valid.
// Throughput: one beat per cycle while out_stall does not hold a waiting result.
// Input is taken while a result waits at the output, as long as the input register is free.
// Reset clears all scheduler state and empties both registers; hang_frames resets to 0
// and frame_period_us to 40000.
`timescale 1ns / 1ps

module tx_frame_slot_scheduler (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  tfs_pkg::sched_in_t             in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output tfs_pkg::sched_out_t            out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tfs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tfs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tfs_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import tfs_pkg::*;

    logic       in_vld_reg;
    sched_in_t  in_beat_reg;
    logic       out_vld_reg;
    sched_out_t out_beat_reg;
    sched_out_t result;
    tfs_cfg_t   cfg;
    logic       exec;

    tfs_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tfs_slot_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .exec   (exec),
        .beat   (in_beat_reg),
        .cfg    (cfg),
        .result (result)
    );

    // a held beat moves on when the result register is free or draining
    assign exec     = in_vld_reg & ~(out_vld_reg & out_stall);
    assign in_stall = in_vld_reg & out_vld_reg & out_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (!in_stall)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_beat_reg <= in_data;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (exec)
            out_vld_reg <= 1'b1;
        else if (!out_stall)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (exec)
            out_beat_reg <= result;
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_beat_reg;

endmodule
